[rtl/tlsgd_pkg.sv]
package tlsgd_pkg;

  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned THRESH_W = 23;
  localparam int unsigned DWELL_W  = 16;
  localparam int unsigned CFG_W    = 23;
  localparam int unsigned NUM_CH   = 3;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 23'd4000;
  localparam logic [DWELL_W-1:0]  DWELL_RESET  = 16'd10;
  localparam logic [STAMP_W-1:0]  WRAP_GUARD   = 32'hFC00_0000;
  localparam logic [STAMP_W-1:0]  WRAP_SHIFT   = 32'h1FFF_FFFF;

  // Configuration register indexes.
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_MIN_DWELL = 1'b1;

  // Channel order within the lanes.
  localparam int unsigned CH_BOTTOM = 0;
  localparam int unsigned CH_LEFT   = 1;
  localparam int unsigned CH_RIGHT  = 2;

  typedef enum logic [2:0] {
    GEST_NONE  = 3'd0,
    GEST_UP    = 3'd1,
    GEST_DOWN  = 3'd2,
    GEST_LEFT  = 3'd3,
    GEST_RIGHT = 3'd4,
    GEST_PROX  = 3'd5
  } gesture_code_t;

  // Load enables of the pipeline stages; accept marks an input transaction.
  typedef struct packed {
    logic accept;
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_en_t;

  // What travels beside the data: an object was seen, or the times must be classified.
  typedef struct packed {
    logic prox;
    logic eval;
  } side_t;

endpackage

[rtl/three_led_swipe_gesture_detector.sv]
// A result is offered after its accepted input has passed stages 1 to 6 and the result register.
// Throughput: one transaction per cycle; each of the seven stages moves on as soon as
// the stage after it is empty or moving, so input stalls only when every stage is full.
// Reset (synchronous, active high) clears all presence flags and latched times, empties
// the pipeline and restores threshold 4000 and minimum dwell 10.
module three_led_swipe_gesture_detector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tlsgd_pkg::STAMP_W-1:0]     sample_time,
  input  logic signed [tlsgd_pkg::SAMPLE_W-1:0] bottom_sample,
  input  logic signed [tlsgd_pkg::SAMPLE_W-1:0] left_sample,
  input  logic signed [tlsgd_pkg::SAMPLE_W-1:0] right_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        gesture,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [tlsgd_pkg::CFG_W-1:0]       cfg_data
);
  import tlsgd_pkg::*;

  logic [THRESH_W-1:0] presence_threshold;
  logic [DWELL_W-1:0]  min_dwell;

  logic [6:1]    v;
  logic [6:1]    en;
  logic          en_out;
  side_t         side [1:6];
  side_t         out_side;
  gesture_code_t out_gest;
  gesture_code_t merge_gest;
  stage_en_t     sen;
  logic          accept;
  logic          any_present;
  logic          near;

  logic [NUM_CH-1:0][SAMPLE_W-1:0] samples;
  logic [NUM_CH-1:0]               present_now;
  logic [NUM_CH-1:0]               recorded;
  logic [NUM_CH-1:0]               far;
  logic [NUM_CH-1:0][STAMP_W-1:0]  mid;
  logic [NUM_CH-1:0]               dwell;

  always_ff @(posedge clk) begin
    if (rst) begin
      presence_threshold <= THRESH_RESET;
      min_dwell          <= DWELL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: presence_threshold <= cfg_data[THRESH_W-1:0];
        REG_MIN_DWELL: min_dwell          <= cfg_data[DWELL_W-1:0];
      endcase
    end
  end

  // Each stage loads when it is empty or its contents move on.
  always_comb begin
    en_out = !out_valid || !out_stall;
    en[6]  = !v[6] || en_out;
    for (int k = 5; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_stall = !en[1];
  assign accept   = in_valid && en[1];

  assign sen.accept = accept;
  assign sen.s1     = en[1];
  assign sen.s2     = en[2];
  assign sen.s3     = en[3];
  assign sen.s4     = en[4];
  assign sen.s5     = en[5];
  assign sen.s6     = en[6];

  assign samples[CH_BOTTOM] = bottom_sample;
  assign samples[CH_LEFT]   = left_sample;
  assign samples[CH_RIGHT]  = right_sample;

  assign any_present = |present_now;
  assign near        = |far;

  for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
    tlsgd_lane u_lane (
      .clk                (clk),
      .rst                (rst),
      .en                 (sen),
      .sample_time        (sample_time),
      .sample             (samples[i]),
      .presence_threshold (presence_threshold),
      .min_dwell          (min_dwell),
      .any_present        (any_present),
      .near               (near),
      .present_now        (present_now[i]),
      .recorded           (recorded[i]),
      .far                (far[i]),
      .mid                (mid[i]),
      .dwell              (dwell[i])
    );
  end

  tlsgd_merge u_merge (
    .clk   (clk),
    .en    (sen),
    .mid   (mid),
    .dwell (dwell),
    .gest  (merge_gest)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (en[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
      if (en_out) begin
        out_valid <= v[6];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side[1].prox <= any_present;
      side[1].eval <= !any_present && (&recorded);
    end
    for (int k = 2; k <= 6; k++) begin
      if (en[k]) begin
        side[k] <= side[k-1];
      end
    end
    if (en_out) begin
      out_side <= side[6];
      if (side[6].prox) begin
        out_gest <= GEST_PROX;
      end else if (side[6].eval) begin
        out_gest <= merge_gest;
      end else begin
        out_gest <= GEST_NONE;
      end
    end
  end

  assign gesture = out_gest;

  // Input can only be held off when the whole pipeline is full behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result register could move");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    accept |=> v[1])
    else $error("accepted transaction did not reach the first stage");

  a_side_exclusive: assert property (@(posedge clk) disable iff (rst)
    v[1] |-> !(side[1].prox && side[1].eval))
    else $error("transaction marked both present and for classification");

  a_no_eval_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_side.eval) |->
      (gesture == GEST_PROX || gesture == GEST_NONE))
    else $error("swipe reported for a transaction that was not classified");

  a_prox_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_side.prox) |-> (gesture == GEST_PROX))
    else $error("object present but result is not PROX");

endmodule

[rtl/tlsgd_lane.sv]
module tlsgd_lane (
  input  logic                               clk,
  input  logic                               rst,
  input  tlsgd_pkg::stage_en_t               en,
  input  logic [tlsgd_pkg::STAMP_W-1:0]      sample_time,
  input  logic [tlsgd_pkg::SAMPLE_W-1:0]     sample,
  input  logic [tlsgd_pkg::THRESH_W-1:0]     presence_threshold,
  input  logic [tlsgd_pkg::DWELL_W-1:0]      min_dwell,
  input  logic                               any_present,
  input  logic                               near,
  output logic                               present_now,
  output logic                               recorded,
  output logic                               far,
  output logic [tlsgd_pkg::STAMP_W-1:0]      mid,
  output logic                               dwell
);
  import tlsgd_pkg::*;

  logic               present;
  logic [STAMP_W-1:0] entry_stamp;
  logic [STAMP_W-1:0] exit_stamp;
  logic [STAMP_W-1:0] entry_next;
  logic [STAMP_W-1:0] exit_next;

  logic [STAMP_W-1:0] e1, x1, e2, x2, e3, d3;

  // A negative reading has its sign bit set and so always counts as present.
  assign present_now = sample[SAMPLE_W-1] | (sample[SAMPLE_W-2:0] >= presence_threshold);

  assign entry_next = (present_now && !present) ? sample_time : entry_stamp;
  assign exit_next  = (!present_now && present) ? sample_time : exit_stamp;
  assign recorded   = (entry_next != '0) && (exit_next != '0);
  assign far        = (e1 > WRAP_GUARD) || (x1 > WRAP_GUARD);

  always_ff @(posedge clk) begin
    if (rst) begin
      present     <= 1'b0;
      entry_stamp <= '0;
      exit_stamp  <= '0;
    end else if (en.accept) begin
      present <= present_now;
      // Once every channel is clear the times have been used and are forgotten.
      if (any_present) begin
        entry_stamp <= entry_next;
        exit_stamp  <= exit_next;
      end else begin
        entry_stamp <= '0;
        exit_stamp  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      e1 <= entry_next;
      x1 <= exit_next;
    end
    if (en.s2) begin
      e2 <= e1 + (near ? WRAP_SHIFT : '0);
      x2 <= x1 + (near ? WRAP_SHIFT : '0);
    end
    if (en.s3) begin
      e3 <= e2;
      d3 <= x2 - e2;
    end
    if (en.s4) begin
      mid   <= e3 + {1'b0, d3[STAMP_W-1:1]};
      dwell <= d3 > {{(STAMP_W-DWELL_W){1'b0}}, min_dwell};
    end
  end

endmodule

[rtl/tlsgd_merge.sv]
module tlsgd_merge (
  input  logic                                              clk,
  input  tlsgd_pkg::stage_en_t                              en,
  input  logic [tlsgd_pkg::NUM_CH-1:0][tlsgd_pkg::STAMP_W-1:0] mid,
  input  logic [tlsgd_pkg::NUM_CH-1:0]                      dwell,
  output tlsgd_pkg::gesture_code_t                          gest
);
  import tlsgd_pkg::*;

  function automatic logic [STAMP_W-1:0] absdiff(input logic [STAMP_W-1:0] a,
                                                 input logic [STAMP_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic [STAMP_W-1:0] dx5, dy1_5, dy2_5;
  logic               lt_bl5, le_br5, gt_bl5, gt_br5, lt_rl5, lt_br5, lt_lr5, dw5;

  logic [STAMP_W:0]   sum6;
  logic [STAMP_W-1:0] dx6;
  logic               c1_6, c2_6;
  logic               lt_bl6, le_br6, gt_bl6, gt_br6, lt_rl6, lt_br6, lt_lr6, dw6;
  logic               gt_half;

  always_ff @(posedge clk) begin
    if (en.s5) begin
      dx5    <= absdiff(mid[CH_LEFT], mid[CH_RIGHT]);
      dy1_5  <= absdiff(mid[CH_BOTTOM], mid[CH_LEFT]);
      dy2_5  <= absdiff(mid[CH_BOTTOM], mid[CH_RIGHT]);
      lt_bl5 <= mid[CH_BOTTOM] < mid[CH_LEFT];
      le_br5 <= mid[CH_BOTTOM] <= mid[CH_RIGHT];
      gt_bl5 <= mid[CH_BOTTOM] > mid[CH_LEFT];
      gt_br5 <= mid[CH_BOTTOM] > mid[CH_RIGHT];
      lt_rl5 <= mid[CH_RIGHT] < mid[CH_LEFT];
      lt_br5 <= mid[CH_BOTTOM] < mid[CH_RIGHT];
      lt_lr5 <= mid[CH_LEFT] < mid[CH_RIGHT];
      dw5    <= |dwell;
    end
    if (en.s6) begin
      sum6   <= {1'b0, dy1_5} + {1'b0, dy2_5};
      dx6    <= dx5;
      c1_6   <= dy1_5 > dx5;
      c2_6   <= dy2_5 > dx5;
      lt_bl6 <= lt_bl5;
      le_br6 <= le_br5;
      gt_bl6 <= gt_bl5;
      gt_br6 <= gt_br5;
      lt_rl6 <= lt_rl5;
      lt_br6 <= lt_br5;
      lt_lr6 <= lt_lr5;
      dw6    <= dw5;
    end
  end

  // The horizontal spread is weighed against the mean of the two vertical spreads.
  assign gt_half = dx6 > sum6[STAMP_W:1];

  always_comb begin
    if (!dw6) begin
      gest = GEST_NONE;
    end else if ((lt_bl6 && c1_6) || (le_br6 && c2_6)) begin
      gest = GEST_UP;
    end else if ((gt_bl6 && c1_6) || (gt_br6 && c2_6)) begin
      gest = GEST_DOWN;
    end else if (lt_bl6 && lt_rl6 && gt_half) begin
      gest = GEST_LEFT;
    end else if (lt_br6 && lt_lr6 && gt_half) begin
      gest = GEST_RIGHT;
    end else begin
      gest = GEST_NONE;
    end
  end

endmodule
